### src/ecpr_pkg.sv
// ----------------------------------------------------------------------------
// ecpr_pkg
// Shared types, field widths and command/status bundles for the enhanced
// clock page replacement block.
// ----------------------------------------------------------------------------
package ecpr_pkg;

  localparam int FRAMES_DEFAULT = 64;

  localparam int ACTION_W    = 2;
  localparam int INDEX_W     = 6;
  localparam int VICTIM_W    = 6;
  localparam int COUNT_W     = 7;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 8;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

  typedef enum logic [ACTION_W-1:0] {
    ACT_REFERENCE = 2'd0,
    ACT_INSTALL   = 2'd1,
    ACT_RELEASE   = 2'd2,
    ACT_SELECT    = 2'd3
  } action_t;

  // Per-frame entry as stored in the frame table
  typedef struct packed {
    logic occ;
    logic used;
    logic modified;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;
    logic load_item;
    logic start_scan;
    logic rd_item;
    logic rd_hand;
    logic wr_item;
    logic scan_eval;
    logic post;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic scan_end;
    logic out_free;
  } stat_t;

endpackage

### src/ecpr_ram.sv
// ----------------------------------------------------------------------------
// ecpr_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ecpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/ecpr_ctrl.sv
// ----------------------------------------------------------------------------
// ecpr_ctrl
// Sequencer for the replacement block: clearing pass, item decode, table
// read/write steps, clock scan loop and result posting.
// ----------------------------------------------------------------------------
module ecpr_ctrl
  import ecpr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic [ACTION_W-1:0] s_tuser,
  output logic                s_tready,
  input  stat_t               stat,
  output cmd_t                cmd
);

  typedef enum logic [7:0] {
    ST_CLEAR      = 8'b0000_0001,
    ST_IDLE       = 8'b0000_0010,
    ST_ITEM_RD    = 8'b0000_0100,
    ST_ITEM_WR    = 8'b0000_1000,
    ST_SCAN_START = 8'b0001_0000,
    ST_SCAN_RD    = 8'b0010_0000,
    ST_SCAN_EV    = 8'b0100_0000,
    ST_POST       = 8'b1000_0000
  } state_t;

  state_t  state;
  state_t  state_next;
  action_t in_action;

  assign in_action = action_t'(s_tuser);
  assign s_tready  = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load_item = 1'b1;
          unique case (in_action)
            ACT_SELECT:    state_next = ST_SCAN_START;
            ACT_REFERENCE: state_next = ST_ITEM_RD;
            ACT_INSTALL,
            ACT_RELEASE:   state_next = ST_ITEM_WR;
            default:       state_next = ST_ITEM_WR;
          endcase
        end
      end
      ST_ITEM_RD: begin
        cmd.rd_item = 1'b1;
        state_next  = ST_ITEM_WR;
      end
      ST_ITEM_WR: begin
        cmd.wr_item = 1'b1;
        state_next  = ST_POST;
      end
      ST_SCAN_START: begin
        cmd.start_scan = 1'b1;
        state_next     = ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        cmd.rd_hand = 1'b1;
        state_next  = ST_SCAN_EV;
      end
      ST_SCAN_EV: begin
        cmd.scan_eval = 1'b1;
        state_next    = stat.scan_end ? ST_POST : ST_SCAN_RD;
      end
      ST_POST: begin
        if (stat.out_free) begin
          cmd.post   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // One item at a time: nothing new is taken right after an accept
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    cmd.load_item |=> !s_tready)
    else $error("ecpr_ctrl: request accepted while previous one in flight");

  // A result is only posted into a free output register
  a_post_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POST) && !stat.out_free |=> (state == ST_POST))
    else $error("ecpr_ctrl: left post state with output register full");

  // Clearing pass finishes before any request is taken
  a_clear_first: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !cmd.load_item && !cmd.post)
    else $error("ecpr_ctrl: activity during clearing pass");

endmodule

### src/ecpr_dp.sv
// ----------------------------------------------------------------------------
// ecpr_dp
// Datapath: frame table RAM, clock hand, scan counters, frame count register
// and the output result register.
// ----------------------------------------------------------------------------
module ecpr_dp
  import ecpr_pkg::*;
#(
  parameter int FRAMES = FRAMES_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [COUNT_W-1:0]     cfg_data,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic [ACTION_W-1:0]    s_tuser,
  input  cmd_t                   cmd,
  output stat_t                  stat,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tuser
);

  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);
  localparam int LW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam logic [LW-1:0] FRAMES_L = LW'(FRAMES);

  logic [COUNT_W-1:0]  frame_count;
  action_t             act;
  logic [INDEX_W-1:0]  idx;
  logic                wr;
  logic [FW-1:0]       hand;
  logic [FW-1:0]       hand_saved;
  logic [LW-1:0]       step;
  logic [1:0]          pass;
  logic                seen;
  logic [FW-1:0]       clr_addr;
  logic [VICTIM_W-1:0] res_frame;
  logic                res_dirty;
  logic                res_none;

  logic [LW-1:0] n_live;
  logic [LW-1:0] fc_l;
  logic [LW-1:0] hand_l;
  logic [LW-1:0] hand_inc;
  logic [FW-1:0] hand_adv;
  logic          in_range;
  logic          last_step;
  logic          hit;
  logic          seen_next;
  logic          empty;
  logic          exhausted;

  logic          ram_we;
  logic [FW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic          ram_re;
  logic [FW-1:0] ram_raddr;
  entry_t        rdata;

  // Effective frame count: zero acts as one, oversize clamps to FRAMES
  assign fc_l = LW'(frame_count);
  always_comb begin
    if (frame_count == '0) begin
      n_live = LW'(1);
    end else if (fc_l > FRAMES_L) begin
      n_live = FRAMES_L;
    end else begin
      n_live = fc_l;
    end
  end

  assign in_range  = LW'(idx) < n_live;
  assign hand_l    = LW'(hand);
  assign hand_inc  = hand_l + LW'(1);
  assign hand_adv  = (hand_inc >= n_live) ? '0 : FW'(hand_inc);
  assign last_step = (step == n_live - LW'(1));

  // Scan decision on the entry under the hand
  assign hit       = rdata.occ && (pass[0] ? !rdata.used : (!rdata.used && !rdata.modified));
  assign seen_next = seen || rdata.occ;
  assign empty     = last_step && (pass == 2'd0) && !seen_next;
  assign exhausted = last_step && (pass == 2'd3);

  assign stat.clr_last = (clr_addr == FW'(FRAMES - 1));
  assign stat.scan_end = hit || empty || exhausted;
  assign stat.out_free = !m_tvalid || m_tready;

  assign ram_re    = cmd.rd_item || cmd.rd_hand;
  assign ram_raddr = cmd.rd_hand ? hand : FW'(idx);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = hand;
    ram_wdata = '0;
    if (cmd.clear) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
    end else if (cmd.wr_item) begin
      ram_waddr = FW'(idx);
      unique case (act)
        ACT_REFERENCE: begin
          ram_we    = in_range && rdata.occ;
          ram_wdata = '{occ: 1'b1, used: 1'b1, modified: rdata.modified || wr};
        end
        ACT_INSTALL: begin
          ram_we    = in_range;
          ram_wdata = '{occ: 1'b1, used: 1'b1, modified: 1'b0};
        end
        ACT_RELEASE: begin
          ram_we    = in_range;
          ram_wdata = '0;
        end
        ACT_SELECT: begin
          ram_we = 1'b0;
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end else if (cmd.scan_eval) begin
      if (hit) begin
        ram_we    = 1'b1;
        ram_wdata = '{occ: 1'b1, used: 1'b1, modified: 1'b0};
      end else if (rdata.occ && pass[0] && rdata.used) begin
        // second-chance pass: clear the use bit as the hand goes by
        ram_we    = 1'b1;
        ram_wdata = '{occ: 1'b1, used: 1'b0, modified: rdata.modified};
      end
    end
  end

  ecpr_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(FRAMES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= COUNT_RESET;
      hand        <= '0;
      clr_addr    <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        frame_count <= cfg_data;
      end
      if (cmd.clear) begin
        clr_addr <= clr_addr + FW'(1);
      end
      if (cmd.start_scan && (hand_l >= n_live)) begin
        hand <= '0;
      end
      if (cmd.scan_eval) begin
        hand <= (empty && !hit) ? hand_saved : hand_adv;
      end
      if (cmd.post) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Item payload, scan counters and result
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      act       <= action_t'(s_tuser);
      idx       <= s_tdata[INDEX_W-1:0];
      wr        <= s_tdata[INDEX_W];
      res_frame <= '0;
      res_dirty <= 1'b0;
      res_none  <= 1'b0;
    end
    if (cmd.start_scan) begin
      hand_saved <= hand;
      step       <= '0;
      pass       <= 2'd0;
      seen       <= 1'b0;
    end
    if (cmd.scan_eval) begin
      if (hit) begin
        res_frame <= VICTIM_W'(hand);
        res_dirty <= rdata.modified;
      end else begin
        if (empty || exhausted) begin
          res_none <= 1'b1;
        end
        step <= last_step ? '0 : step + LW'(1);
        pass <= pass + 2'(last_step);
        seen <= seen_next;
      end
    end
    if (cmd.post) begin
      m_tdata <= OUT_TDATA_W'({res_dirty, res_frame});
      m_tuser <= res_none;
    end
  end

  a_post_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.post |=> m_tvalid)
    else $error("ecpr_dp: posted result not presented");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata == '0))
    else $error("ecpr_dp: none_found result carries a frame");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_eval |-> (step < n_live))
    else $error("ecpr_dp: scan step beyond frame count");

  a_port_split: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("ecpr_dp: table read and write in the same cycle");

endmodule

### src/enhanced_clock_page_replacement.sv
// ----------------------------------------------------------------------------
// enhanced_clock_page_replacement
// Enhanced second-chance (clock) frame replacement with occupied, use and
// modified bits per frame and one clock hand.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the frame table, during
// which s_tready stays low (frame_count writes are taken as usual). A request
// then steps through: install or release accept, write, post; reference
// accept, read, write back, post; select accept, scan start, a read and an
// evaluate per frame the hand visits, then post. Each hand step reads the
// single frame table RAM and writes back where it clears the use bit or takes
// a victim. Requests are handled one at a time; a finished result sits in the
// output register while the next request is accepted and worked on. Every
// request yields exactly one result; for anything but a select the
// result is all zero. frame_count may only be written while the block is idle.
// ----------------------------------------------------------------------------
module enhanced_clock_page_replacement
  import ecpr_pkg::*;
#(
  parameter int FRAMES = FRAMES_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  // frame_count write
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [COUNT_W-1:0]     cfg_data,
  // request stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [5:0] frame_index, [6] is_write, [7] zero
  input  logic [ACTION_W-1:0]    s_tuser,   // [1:0] action
  // result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [5:0] victim_frame, [6] victim_was_dirty, [7] zero
  output logic                   m_tuser    // [0] none_found
);

  cmd_t  cmd;
  stat_t stat;

  // frame_count is a plain register: always ready
  assign cfg_ready = 1'b1;

  // Sequencer: owns the request handshake and steps the datapath
  ecpr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tuser (s_tuser),
    .s_tready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  // Frame table, hand, scan counters and output register
  ecpr_dp #(
    .FRAMES(FRAMES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
